@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the RTL of the stack allocator.
// Each macro checks a property on the rising clock edge, disabled while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold on the same edge.
`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the following edge.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg)

`endif

`endif

@@ rtl/core/saoe_pkg.sv @@
`timescale 1ns / 1ps

package saoe_pkg;

    // Buffer geometry.
    localparam int BUFFER_BYTES   = 4096;
    localparam int PAD_IDX_W      = $clog2(BUFFER_BYTES);
    localparam int OFF_W          = 13;
    localparam int PAD_W          = 8;
    localparam int ADDR_W         = 32;
    localparam int SIZE_W         = 16;
    localparam int ALIGN_W        = 4;
    localparam int MAX_ALIGN_LOG2 = 8;

    // Width of a sum of an offset and a requested size.
    localparam int END_W          = SIZE_W + 1;

    // Request codes.
    typedef enum logic [1:0] {
        CMD_ALLOC    = 2'd0,
        CMD_FREE     = 2'd1,
        CMD_RESIZE   = 2'd2,
        CMD_FREE_ALL = 2'd3
    } cmd_t;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_BOUNDS   = 2'd2;
    localparam logic [1:0] ST_FREED    = 2'd3;

    // Configuration register indexes.
    localparam logic REG_BASE_ADDRESS  = 1'b0;
    localparam logic REG_BUFFER_LENGTH = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

@@ rtl/core/saoe_ctrl.sv @@
`timescale 1ns / 1ps

module saoe_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    output saoe_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state: an accepted item goes from idle into execution and then straight back to idle.
    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == S_EXEC);

endmodule

@@ rtl/core/saoe_datapath.sv @@
`timescale 1ns / 1ps

module saoe_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  saoe_pkg::ctrl_cmd_t                    cmd,
    input  logic [saoe_pkg::ADDR_W-1:0]            base_address,
    input  logic [saoe_pkg::OFF_W-1:0]             eff_len,
    input  logic [1:0]                             in_cmd,
    input  logic [saoe_pkg::SIZE_W-1:0]            in_req_size,
    input  logic [saoe_pkg::SIZE_W-1:0]            in_prev_size,
    input  logic [saoe_pkg::ALIGN_W-1:0]           in_align_log2,
    input  logic [saoe_pkg::ADDR_W-1:0]            in_ptr_addr,
    input  logic                                   in_ptr_is_null,
    output logic [saoe_pkg::ADDR_W-1:0]            result_address,
    output logic                                   result_is_null,
    output logic [1:0]                             status,
    output logic [saoe_pkg::SIZE_W-1:0]            copy_length,
    output logic                                   done
);

    // Captured item.
    saoe_pkg::cmd_t                      cmd_reg;
    logic [saoe_pkg::SIZE_W-1:0]         req_reg;
    logic [saoe_pkg::SIZE_W-1:0]         old_reg;
    logic [saoe_pkg::ALIGN_W-1:0]        lg_reg;
    logic [saoe_pkg::ADDR_W-1:0]         ptr_reg;
    logic                                pnull_reg;

    // Allocator state and padding store.
    logic [saoe_pkg::OFF_W-1:0]          top_reg;
    logic [saoe_pkg::OFF_W-1:0]          top_next;
    logic [saoe_pkg::PAD_W-1:0]          pad_mem [0:saoe_pkg::BUFFER_BYTES-1];
    logic [saoe_pkg::PAD_W-1:0]          pad_rd_reg;
    logic [saoe_pkg::ADDR_W-1:0]         in_off;
    logic [saoe_pkg::PAD_IDX_W-1:0]      rd_idx;
    logic                                pad_we;
    logic [saoe_pkg::PAD_IDX_W-1:0]      wr_idx;

    // Result registers.
    logic [saoe_pkg::ADDR_W-1:0]         addr_reg;
    logic [saoe_pkg::ADDR_W-1:0]         addr_next;
    logic                                rnull_reg;
    logic                                rnull_next;
    logic [1:0]                          st_reg;
    logic [1:0]                          st_next;
    logic [saoe_pkg::SIZE_W-1:0]         copy_reg;
    logic [saoe_pkg::SIZE_W-1:0]         copy_next;
    logic                                done_reg;

    // Allocation arithmetic.
    logic [saoe_pkg::ALIGN_W-1:0]        lg_sat;
    logic [saoe_pkg::PAD_W-1:0]          align_mask;
    logic [saoe_pkg::PAD_W-1:0]          cur_low;
    logic [saoe_pkg::PAD_W-1:0]          pad_new;
    logic [saoe_pkg::OFF_W-1:0]          data_off;
    logic [saoe_pkg::END_W-1:0]          alloc_end;
    logic                                alloc_ovf;
    logic [saoe_pkg::ADDR_W-1:0]         alloc_addr;

    // Pointer check and rewind arithmetic.
    logic [saoe_pkg::ADDR_W-1:0]         ptr_off;
    logic [1:0]                          chk_st;
    logic [saoe_pkg::OFF_W:0]            pad_plus1;
    logic [saoe_pkg::OFF_W-1:0]          rewind_top;

    // Path selection.
    logic                                sel_alloc;
    logic                                sel_free;
    logic                                sel_keep;
    logic                                sel_realloc;

    // The header byte of a freed block sits just before its data address.
    assign in_off = in_ptr_addr - base_address;
    assign rd_idx = saoe_pkg::PAD_IDX_W'(in_off - saoe_pkg::ADDR_W'(1));

    // Capture the item at acceptance.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg   <= saoe_pkg::cmd_t'(in_cmd);
            req_reg   <= in_req_size;
            old_reg   <= in_prev_size;
            lg_reg    <= in_align_log2;
            ptr_reg   <= in_ptr_addr;
            pnull_reg <= in_ptr_is_null;
        end
    end

    // Padding store: read at acceptance, written when an allocation succeeds.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pad_rd_reg <= pad_mem[rd_idx];
        end
        if (pad_we)
        begin
            pad_mem[wr_idx] <= pad_new;
        end
    end

    // Alignment: pad the header so that the data address is aligned.
    assign lg_sat     = (lg_reg > saoe_pkg::ALIGN_W'(saoe_pkg::MAX_ALIGN_LOG2))
                        ? saoe_pkg::ALIGN_W'(saoe_pkg::MAX_ALIGN_LOG2) : lg_reg;
    assign align_mask = saoe_pkg::PAD_W'((9'd1 << lg_sat) - 9'd1);
    assign cur_low    = base_address[saoe_pkg::PAD_W-1:0] + top_reg[saoe_pkg::PAD_W-1:0]
                        + saoe_pkg::PAD_W'(1);
    assign pad_new    = (saoe_pkg::PAD_W'(0) - cur_low) & align_mask;
    assign data_off   = top_reg + saoe_pkg::OFF_W'(1) + saoe_pkg::OFF_W'(pad_new);
    assign alloc_end  = saoe_pkg::END_W'(data_off) + saoe_pkg::END_W'(req_reg);
    assign alloc_ovf  = alloc_end > saoe_pkg::END_W'(eff_len);
    assign alloc_addr = base_address + saoe_pkg::ADDR_W'(data_off);
    assign wr_idx     = saoe_pkg::PAD_IDX_W'(data_off - saoe_pkg::OFF_W'(1));

    // Pointer bounds check against the base, the buffer end and the top.
    assign ptr_off = ptr_reg - base_address;
    always_comb
    begin
        if ((ptr_off == '0) || (ptr_off >= saoe_pkg::ADDR_W'(eff_len)))
        begin
            chk_st = saoe_pkg::ST_BOUNDS;
        end
        else if (ptr_off[saoe_pkg::OFF_W-1:0] >= top_reg)
        begin
            chk_st = saoe_pkg::ST_FREED;
        end
        else
        begin
            chk_st = saoe_pkg::ST_OK;
        end
    end

    // Rewind the top to where it stood before the freed allocation.
    assign pad_plus1  = (saoe_pkg::OFF_W+1)'(pad_rd_reg) + (saoe_pkg::OFF_W+1)'(1);
    assign rewind_top = (pad_plus1 > (saoe_pkg::OFF_W+1)'(ptr_off[saoe_pkg::OFF_W-1:0]))
                        ? '0
                        : ptr_off[saoe_pkg::OFF_W-1:0] - saoe_pkg::OFF_W'(pad_plus1);

    // Decide which operation the item performs.
    always_comb
    begin
        sel_alloc   = 1'b0;
        sel_free    = 1'b0;
        sel_keep    = 1'b0;
        sel_realloc = 1'b0;
        unique case (cmd_reg)
            saoe_pkg::CMD_ALLOC:
            begin
                sel_alloc = 1'b1;
            end
            saoe_pkg::CMD_FREE:
            begin
                sel_free = !pnull_reg;
            end
            saoe_pkg::CMD_RESIZE:
            begin
                if (pnull_reg)
                begin
                    sel_alloc = 1'b1;
                end
                else if (req_reg == '0)
                begin
                    sel_free = 1'b1;
                end
                else if (chk_st == saoe_pkg::ST_OK)
                begin
                    sel_keep    = (old_reg == req_reg);
                    sel_realloc = (old_reg != req_reg);
                    sel_alloc   = (old_reg != req_reg);
                end
            end
            saoe_pkg::CMD_FREE_ALL:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Result and top update for the executing item.
    always_comb
    begin
        top_next   = top_reg;
        addr_next  = '0;
        rnull_next = 1'b1;
        st_next    = saoe_pkg::ST_OK;
        copy_next  = '0;
        pad_we     = 1'b0;
        priority if (cmd_reg == saoe_pkg::CMD_FREE_ALL)
        begin
            top_next = '0;
        end
        else if (sel_alloc)
        begin
            if (alloc_ovf)
            begin
                st_next = saoe_pkg::ST_OVERFLOW;
            end
            else
            begin
                top_next   = saoe_pkg::OFF_W'(alloc_end);
                addr_next  = alloc_addr;
                rnull_next = 1'b0;
                pad_we     = cmd.execute;
                if (sel_realloc)
                begin
                    copy_next = (old_reg < req_reg) ? old_reg : req_reg;
                end
            end
        end
        else if (sel_free)
        begin
            st_next = chk_st;
            if (chk_st == saoe_pkg::ST_OK)
            begin
                top_next = rewind_top;
            end
        end
        else if (sel_keep)
        begin
            addr_next  = ptr_reg;
            rnull_next = 1'b0;
        end
        else if ((cmd_reg == saoe_pkg::CMD_RESIZE) && !pnull_reg)
        begin
            st_next = chk_st;
        end
        else
        begin
            st_next = saoe_pkg::ST_OK;
        end
    end

    // Top offset register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else if (cmd.execute)
        begin
            top_reg <= top_next;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            addr_reg  <= addr_next;
            rnull_reg <= rnull_next;
            st_reg    <= st_next;
            copy_reg  <= copy_next;
        end
    end

    assign result_address = addr_reg;
    assign result_is_null = rnull_reg;
    assign status         = st_reg;
    assign copy_length    = copy_reg;
    assign done           = done_reg;

endmodule

@@ rtl/core/stack_allocator_offset_engine.sv @@
`timescale 1ns / 1ps

// Stack allocator offset engine with a one-byte padding header per allocation.
// Requests enter on start while busy is low; the fields cmd, req_size, prev_size,
// align_log2, ptr_addr and ptr_is_null are sampled at that edge. Commands are
// alloc, free, resize and free all.
// Each request gives exactly one result on result_address, result_is_null,
// status and copy_length, marked by done for a single cycle. The request is
// captured at acceptance and runs in the execute state, at whose end done and
// the result are registered; the receiver cannot stall it. A new request may be
// accepted in the cycle in which done is shown, but not while busy is high, so
// the block finishes one request before it takes the next. The padding store
// sets this: its read is issued at acceptance and its registered data is used
// in the execute cycle, where the top offset is also updated.
// The registers base_address (index 0) and buffer_length (index 1) are written
// through wr_en, wr_index and wr_data. The user must write them only while the
// block is idle; the block does not enforce it. Reset clears the top offset and
// base_address, sets buffer_length to the full store depth, keeps the pad store.
module stack_allocator_offset_engine
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [1:0]                             cmd,
    input  logic [saoe_pkg::SIZE_W-1:0]            req_size,
    input  logic [saoe_pkg::SIZE_W-1:0]            prev_size,
    input  logic [saoe_pkg::ALIGN_W-1:0]           align_log2,
    input  logic [saoe_pkg::ADDR_W-1:0]            ptr_addr,
    input  logic                                   ptr_is_null,
    input  logic                                   wr_en,
    input  logic                                   wr_index,
    input  logic [saoe_pkg::ADDR_W-1:0]            wr_data,
    output logic                                   done,
    output logic [saoe_pkg::ADDR_W-1:0]            result_address,
    output logic                                   result_is_null,
    output logic [1:0]                             status,
    output logic [saoe_pkg::SIZE_W-1:0]            copy_length
);

    `include "assert_macros.svh"

    logic [saoe_pkg::ADDR_W-1:0]  base_address_reg;
    logic [saoe_pkg::OFF_W-1:0]   buffer_length_reg;
    logic [saoe_pkg::OFF_W-1:0]   eff_len;
    saoe_pkg::ctrl_cmd_t          ctrl_cmd;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_address_reg  <= '0;
            buffer_length_reg <= saoe_pkg::OFF_W'(saoe_pkg::BUFFER_BYTES);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                saoe_pkg::REG_BASE_ADDRESS:
                begin
                    base_address_reg <= wr_data;
                end
                saoe_pkg::REG_BUFFER_LENGTH:
                begin
                    buffer_length_reg <= wr_data[saoe_pkg::OFF_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // A buffer length beyond the store depth is limited to the depth.
    assign eff_len = (buffer_length_reg > saoe_pkg::OFF_W'(saoe_pkg::BUFFER_BYTES))
                     ? saoe_pkg::OFF_W'(saoe_pkg::BUFFER_BYTES) : buffer_length_reg;

    saoe_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (ctrl_cmd)
    );

    saoe_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .base_address   (base_address_reg),
        .eff_len        (eff_len),
        .in_cmd         (cmd),
        .in_req_size    (req_size),
        .in_prev_size   (prev_size),
        .in_align_log2  (align_log2),
        .in_ptr_addr    (ptr_addr),
        .in_ptr_is_null (ptr_is_null),
        .result_address (result_address),
        .result_is_null (result_is_null),
        .status         (status),
        .copy_length    (copy_length),
        .done           (done)
    );

    // Every execute cycle is followed by exactly one result strobe.
    `ASSERT_NEXT(a_exec_gives_result, clk, rst_n, busy, done, "execution gave no result")

    // Results never come in two consecutive cycles.
    `ASSERT_NEXT(a_single_strobe, clk, rst_n, done, !done, "result strobe held too long")

    // A null result carries a zero address.
    `ASSERT_IMPLY(a_null_zero_addr, clk, rst_n, done && result_is_null,
        result_address == '0, "null result with non-zero address")

    // Only a successful request reports a copy length.
    `ASSERT_IMPLY(a_copy_only_ok, clk, rst_n, done && (status != saoe_pkg::ST_OK),
        copy_length == '0, "copy length reported on a failed request")

endmodule

@@ tb/stack_allocator_offset_engine_tb.sv @@
`timescale 1ns / 1ps

module stack_allocator_offset_engine_tb;

    import saoe_pkg::*;

    localparam int NUM_DIRECTED    = 24;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 106;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PRINT_CAP       = 40;

    // One request item as driven on the input ports.
    typedef struct packed {
        cmd_t        op;
        logic [15:0] req;
        logic [15:0] old;
        logic [3:0]  lg;
        logic [31:0] ptr;
        logic        pnull;
    } request_t;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic [31:0] addr;
        logic        is_null;
        logic [1:0]  status;
        logic [15:0] copy;
    } outcome_t;

    // A directed row: the request, and an expected outcome where it is typed in.
    typedef struct packed {
        request_t rq;
        logic     typed;
        outcome_t want;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [15:0] req_size;
    logic [15:0] prev_size;
    logic [3:0]  align_log2;
    logic [31:0] ptr_addr;
    logic        ptr_is_null;
    logic        wr_en;
    logic        wr_index;
    logic [31:0] wr_data;
    logic        done;
    logic [31:0] result_address;
    logic        result_is_null;
    logic [1:0]  status;
    logic [15:0] copy_length;

    // Shadow copy of the allocator state.
    logic [31:0] cfg_base;
    logic [12:0] cfg_len;
    logic [12:0] top_off;
    logic [7:0]  pad_bytes [0:BUFFER_BYTES-1];
    bit          pad_written [0:BUFFER_BYTES-1];

    outcome_t    pending_results [$];
    logic [31:0] live_addrs [$];
    dir_row_t    directed [NUM_DIRECTED];

    int error_count;
    int cycle_count;
    int n_alloc, n_free, n_resize, n_free_all;
    int n_ok, n_overflow, n_bounds, n_freed, n_copies;

    stack_allocator_offset_engine dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .req_size       (req_size),
        .prev_size      (prev_size),
        .align_log2     (align_log2),
        .ptr_addr       (ptr_addr),
        .ptr_is_null    (ptr_is_null),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .done           (done),
        .result_address (result_address),
        .result_is_null (result_is_null),
        .status         (status),
        .copy_length    (copy_length)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run length guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("stack_allocator_offset_engine: mismatch");
            $finish;
        end
    end

    // Usable length: anything above the store depth acts as the full store.
    function automatic int usable_len();
        return (cfg_len > BUFFER_BYTES) ? BUFFER_BYTES : int'(cfg_len);
    endfunction

    // Carve a block off the top of the stack, leaving a padding header before it.
    function automatic logic [1:0] carve_block(input logic [15:0] size, input logic [3:0] lg_in,
                                               output logic [31:0] addr);
        longint unsigned align, cur, data_abs, data_off, pad;
        int lg;
        lg       = (lg_in > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : int'(lg_in);
        align    = 64'd1 << lg;
        cur      = 64'(cfg_base) + 64'(top_off);
        data_abs = (cur + align) & ~(align - 64'd1);
        pad      = data_abs - 64'd1 - cur;
        data_off = data_abs - 64'(cfg_base);
        addr     = 32'd0;
        if (pad > 64'd255 || data_off + 64'(size) > 64'(usable_len()))
            return ST_OVERFLOW;
        pad_bytes[int'(data_off - 64'd1) % BUFFER_BYTES]   = 8'(pad);
        pad_written[int'(data_off - 64'd1) % BUFFER_BYTES] = 1'b1;
        top_off = 13'(data_off + 64'(size));
        addr    = 32'(data_abs);
        return ST_OK;
    endfunction

    // Bounds and liveness check of a non-null pointer.
    function automatic logic [1:0] vet_pointer(input logic [31:0] ptr, output logic [31:0] off);
        off = ptr - cfg_base;
        if (off == 32'd0 || off >= 32'(usable_len()))
            return ST_BOUNDS;
        if (off >= 32'(top_off))
            return ST_FREED;
        return ST_OK;
    endfunction

    // Rewind the top to where it stood before the block at ptr was carved.
    function automatic logic [1:0] rewind_to_block(input logic [31:0] ptr);
        logic [31:0] off;
        logic [1:0]  st;
        logic [31:0] pad;
        st = vet_pointer(ptr, off);
        if (st != ST_OK)
            return st;
        pad     = 32'(pad_bytes[int'(off) - 1]);
        top_off = (pad + 32'd1 > off) ? 13'd0 : 13'(off - 32'd1 - pad);
        return ST_OK;
    endfunction

    // Expected outcome of one request; updates the shadow state as the block would.
    function automatic outcome_t allocator_outcome(input request_t r);
        outcome_t    o;
        logic [31:0] off;
        logic [31:0] addr;
        logic [1:0]  st;
        logic        rnull;
        logic [15:0] copy;
        addr  = 32'd0;
        st    = ST_OK;
        rnull = 1'b1;
        copy  = 16'd0;
        case (r.op)
            CMD_ALLOC:
            begin
                st    = carve_block(r.req, r.lg, addr);
                rnull = (st != ST_OK);
            end
            CMD_FREE:
            begin
                if (!r.pnull)
                    st = rewind_to_block(r.ptr);
            end
            CMD_RESIZE:
            begin
                if (r.pnull)
                begin
                    st    = carve_block(r.req, r.lg, addr);
                    rnull = (st != ST_OK);
                end
                else if (r.req == 16'd0)
                    st = rewind_to_block(r.ptr);
                else
                begin
                    st = vet_pointer(r.ptr, off);
                    if (st == ST_OK)
                    begin
                        if (r.old == r.req)
                        begin
                            addr  = r.ptr;
                            rnull = 1'b0;
                        end
                        else
                        begin
                            st    = carve_block(r.req, r.lg, addr);
                            rnull = (st != ST_OK);
                            if (!rnull)
                                copy = (r.old < r.req) ? r.old : r.req;
                        end
                    end
                end
            end
            default:
                top_off = 13'd0;
        endcase
        o.addr    = rnull ? 32'd0 : addr;
        o.is_null = rnull;
        o.status  = st;
        o.copy    = copy;
        return o;
    endfunction

    // Request sizes: mostly small, a few that reach the end of the buffer or far past it.
    function automatic logic [15:0] draw_size();
        int k;
        k = $urandom_range(99);
        if (k < 55)
            return 16'($urandom_range(32));
        if (k < 80)
            return 16'($urandom_range(300));
        if (k < 93)
            return 16'($urandom_range(4200));
        return 16'($urandom());
    endfunction

    // A random request that mostly follows stack order on live blocks.
    function automatic request_t draw_request();
        request_t    r;
        logic [31:0] off;
        int          k;
        int          n;
        k = $urandom_range(99);
        if (k < 40)
            r.op = CMD_ALLOC;
        else if (k < 65)
            r.op = CMD_FREE;
        else if (k < 97)
            r.op = CMD_RESIZE;
        else
            r.op = CMD_FREE_ALL;
        r.req = draw_size();
        r.old = ($urandom_range(2) == 0) ? r.req : draw_size();
        k = $urandom_range(9);
        if (k < 6)
            r.lg = 4'($urandom_range(3));
        else if (k < 9)
            r.lg = 4'($urandom_range(8, 4));
        else
            r.lg = 4'($urandom_range(15, 9));
        n = live_addrs.size();
        k = $urandom_range(99);
        if (n > 0 && k < 55)
            r.ptr = live_addrs[n - 1];
        else if (n > 0 && k < 75)
            r.ptr = live_addrs[$urandom_range(n - 1)];
        else if (k < 80)
            r.ptr = cfg_base;
        else if (k < 92)
            r.ptr = cfg_base + 32'($urandom_range(usable_len() + 4));
        else
            r.ptr = $urandom();
        r.pnull = ($urandom_range(7) == 0);
        if (r.op == CMD_RESIZE && $urandom_range(7) == 0)
            r.req = 16'd0;
        // A header byte that was never written must not be read back.
        if (!r.pnull && (r.op == CMD_FREE || (r.op == CMD_RESIZE && r.req == 16'd0)) &&
            vet_pointer(r.ptr, off) == ST_OK && !pad_written[int'(off) - 1])
            r.pnull = 1'b1;
        return r;
    endfunction

    // Sender gaps: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int k;
        k = $urandom_range(99);
        if (k < 50)
            return 0;
        if (k < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("ERROR at %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    // Offer one item after a gap and hold it until the block takes it.
    task automatic issue(input request_t r, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start       <= 1'b1;
        cmd         <= r.op;
        req_size    <= r.req;
        prev_size   <= r.old;
        align_log2  <= r.lg;
        ptr_addr    <= r.ptr;
        ptr_is_null <= r.pnull;
        case (r.op)
            CMD_ALLOC:  n_alloc++;
            CMD_FREE:   n_free++;
            CMD_RESIZE: n_resize++;
            default:    n_free_all++;
        endcase
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(negedge clk);
        wr_en <= 1'b0;
        if (idx == REG_BASE_ADDRESS)
            cfg_base = data;
        else
            cfg_len = data[12:0];
    endtask

    // Compare each result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, address", 32'd0, result_address);
            else
            begin
                want = pending_results.pop_front();
                if (result_address !== want.addr)
                    report_mismatch("result_address", want.addr, result_address);
                if (result_is_null !== want.is_null)
                    report_mismatch("result_is_null", 32'(want.is_null), 32'(result_is_null));
                if (status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(status));
                if (copy_length !== want.copy)
                    report_mismatch("copy_length", 32'(want.copy), 32'(copy_length));
                case (want.status)
                    ST_OK:       n_ok++;
                    ST_OVERFLOW: n_overflow++;
                    ST_BOUNDS:   n_bounds++;
                    default:     n_freed++;
                endcase
                if (want.copy != 16'd0)
                    n_copies++;
            end
        end
    end

    initial
    begin : stimulus
        request_t    rq;
        outcome_t    want;
        logic [31:0] off;
        logic [31:0] base_val;
        logic [12:0] len_val;
        bit          gappy;

        // Known values on every input from the start.
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = CMD_ALLOC;
        req_size    = 16'd0;
        prev_size   = 16'd0;
        align_log2  = 4'd0;
        ptr_addr    = 32'd0;
        ptr_is_null = 1'b0;
        wr_en       = 1'b0;
        wr_index    = REG_BASE_ADDRESS;
        wr_data     = 32'd0;
        cfg_base    = 32'd0;
        cfg_len     = 13'(BUFFER_BYTES);
        top_off     = 13'd0;

        // Directed rows, walked from the reset state (base 0, full buffer).
        directed = '{
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd0,          1'b1},
              1'b1, '{32'd0, 1'b1, ST_OK,       16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_BOUNDS,   16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd5,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_FREED,    16'd0}},
            '{'{CMD_ALLOC,    16'd0,      16'd0,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd1, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_ALLOC,    16'hFFFF,   16'd0,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_OVERFLOW, 16'd0}},
            '{'{CMD_ALLOC,    16'd16,     16'd0,  4'd15, 32'hFFFF_FFFF,  1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_ALLOC,    16'd100,    16'd0,  4'd3,  32'd0,          1'b1},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_RESIZE,   16'd8,      16'd0,  4'd2,  32'hA5A5_A5A5,  1'b1},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_RESIZE,   16'd8,      16'd8,  4'd0,  32'd384,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_RESIZE,   16'd32,     16'd16, 4'd0,  32'd256,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_RESIZE,   16'd4,      16'd50, 4'd0,  32'd280,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_RESIZE,   16'd5,      16'd3,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_BOUNDS,   16'd0}},
            '{'{CMD_RESIZE,   16'd5,      16'd3,  4'd0,  32'd4096,       1'b0},
              1'b1, '{32'd0, 1'b1, ST_BOUNDS,   16'd0}},
            '{'{CMD_RESIZE,   16'd5,      16'd3,  4'd0,  32'd1000,       1'b0},
              1'b1, '{32'd0, 1'b1, ST_FREED,    16'd0}},
            '{'{CMD_RESIZE,   16'd0,      16'd7,  4'd0,  32'd393,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'hFFFF_FFFF,  1'b0},
              1'b1, '{32'd0, 1'b1, ST_BOUNDS,   16'd0}},
            '{'{CMD_RESIZE,   16'hFFFF,   16'd1,  4'd0,  32'd384,        1'b0},
              1'b1, '{32'd0, 1'b1, ST_OVERFLOW, 16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd384,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd256,        1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd1,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_FREED,    16'd0}},
            '{'{CMD_FREE_ALL, 16'hFFFF,   16'hFFFF, 4'd15, 32'hFFFF_FFFF, 1'b1},
              1'b1, '{32'd0, 1'b1, ST_OK,       16'd0}},
            '{'{CMD_ALLOC,    16'd4095,   16'd0,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd1, 1'b0, ST_OK,       16'd0}},
            '{'{CMD_ALLOC,    16'd0,      16'd0,  4'd0,  32'd0,          1'b0},
              1'b1, '{32'd0, 1'b1, ST_OVERFLOW, 16'd0}},
            '{'{CMD_FREE,     16'd0,      16'd0,  4'd0,  32'd1,          1'b0},
              1'b0, '{32'd0, 1'b0, ST_OK,       16'd0}}
        };

        // Hold reset from the start, released away from the rising clock edge.
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: the predictor always runs so that its state follows the block.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            want = allocator_outcome(directed[i].rq);
            if (directed[i].typed)
                want = directed[i].want;
            pending_results.push_back(want);
            issue(directed[i].rq, (i % 4 == 3) ? 2 : 0);
        end

        // Random part, one buffer setting per phase.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    base_val = 32'h0000_1000;
                    len_val  = 13'd4096;
                end
                1:
                begin
                    base_val = 32'hFFFF_FF00;
                    len_val  = 13'd4096;
                end
                2:
                begin
                    base_val = 32'hFFFF_FFFF;
                    len_val  = 13'h1FFF;
                end
                3:
                begin
                    base_val = $urandom();
                    len_val  = 13'd0;
                end
                4:
                begin
                    base_val = $urandom();
                    len_val  = 13'd16;
                end
                5:
                begin
                    base_val = 32'h8000_0003;
                    len_val  = 13'd300;
                end
                6:
                begin
                    base_val = $urandom();
                    len_val  = 13'($urandom());
                end
                default:
                begin
                    base_val = 32'd0;
                    len_val  = 13'd4095;
                end
            endcase

            // Registers change only once the block has gone quiet.
            drain();
            write_reg(REG_BASE_ADDRESS, base_val);
            write_reg(REG_BUFFER_LENGTH, {19'($urandom()), len_val});
            gappy = (p % 3 != 1);

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Pause now and then until everything in flight has returned.
                if (i == ITEMS_PER_PHASE / 2 && p % 2 == 0)
                    drain();
                rq   = draw_request();
                want = allocator_outcome(rq);
                pending_results.push_back(want);
                if (!want.is_null && want.addr != rq.ptr)
                    live_addrs.push_back(want.addr);
                for (int j = live_addrs.size() - 1; j >= 0; j--)
                begin
                    off = live_addrs[j] - cfg_base;
                    if (off == 32'd0 || off >= 32'(top_off))
                        live_addrs.delete(j);
                end
                issue(rq, gappy ? pick_gap() : 0);
            end
        end

        drain();

        $display("Ran %0d allocs, %0d frees, %0d resizes and %0d free-alls over %0d buffer settings.",
                 n_alloc, n_free, n_resize, n_free_all, NUM_PHASES + 1);
        $display("Statuses seen: %0d ok, %0d overflow, %0d out of bounds, %0d ignored; %0d copies.",
                 n_ok, n_overflow, n_bounds, n_freed, n_copies);
        if (error_count == 0)
            $display("stack_allocator_offset_engine: match");
        else
            $display("stack_allocator_offset_engine: mismatch");
        $finish;
    end

endmodule
